### design/assert_macros.svh
// assertion macros for the deframer rtl
// no dependencies; simulation builds get the checks, synthesis gets empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, cond, cons)
`define ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

### design/mhdr_pkg.sv
// shared types and constants of the magic header deframer
// no dependencies; used by magic_header_deframer_resync_unit
package mhdr_pkg;

    // largest payload length a header may announce
    localparam int MAX_PAYLOAD = 512;
    localparam int HDR_BYTES   = 8;
    localparam int FILL_W      = $clog2(HDR_BYTES);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    // event codes of a result item
    typedef enum logic [2:0] {
        EV_HELD    = 3'd0,
        EV_RESYNC  = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_EMPTY   = 3'd3,
        EV_DISCARD = 3'd4,
        EV_IDLE    = 3'd5
    } event_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_TYPE_MIN = 2'd2,
        REG_TYPE_MAX = 2'd3
    } cfg_reg_t;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       clear;
    } byte_item_t;

    // result item
    typedef struct packed {
        event_t             event_res;
        logic [7:0]         frame_type;
        logic [7:0]         frame_flags;
        logic [15:0]        frame_seq;
        logic [LEN_W-1:0]   frame_length;
        logic [7:0]         payload_byte;
        logic               last;
        logic [15:0]        resync_count;
        logic [15:0]        frame_count;
    } res_item_t;

endpackage

### design/magic_header_deframer_resync_unit.sv
// A result appears in the result register in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless an untaken result holds byte_ready low; header
// check, window shift and payload count share the combinational logic ahead of the result register.
// The result register is taken by res_ready in the same cycle a new byte enters.
// Reset (rst_n low, async): window empty, no payload, counters and latched fields zero,
// registers at magic 0, version 0, type range 0..255.
`include "assert_macros.svh"

module magic_header_deframer_resync_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // byte channel
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  mhdr_pkg::byte_item_t        byte_item,
    // result channel
    output logic                        res_valid,
    input  logic                        res_ready,
    output mhdr_pkg::res_item_t         res_item,
    // configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  mhdr_pkg::cfg_reg_t          cfg_index,
    input  logic [7:0]                  cfg_data
);
    import mhdr_pkg::*;

    // configuration registers
    logic [7:0] magic_reg, version_reg, type_min_reg, type_max_reg;

    // deframer state
    logic [7:0]        win_reg [HDR_BYTES];
    logic [7:0]        win_next [HDR_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              in_payload_reg, in_payload_next;
    logic [7:0]        ltype_reg, ltype_next;
    logic [7:0]        lflags_reg, lflags_next;
    logic [15:0]       lseq_reg, lseq_next;
    logic [LEN_W-1:0]  llen_reg, llen_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic [15:0]       resync_reg, resync_next;
    logic [15:0]       frames_reg, frames_next;

    // result register
    logic      res_valid_reg;
    res_item_t res_item_reg;
    res_item_t res_item_next;

    logic byte_accept;
    logic [LEN_W-1:0] seen_inc;
    logic [15:0]      hdr_len;
    logic             hdr_ok;
    event_t           ev;
    logic [7:0]       pbyte;
    logic             last;

    // handshakes
    assign byte_ready  = !res_valid_reg || res_ready;
    assign byte_accept = byte_valid && byte_ready;
    assign cfg_ready   = 1'b1;
    assign res_valid   = res_valid_reg;
    assign res_item    = res_item_reg;

    // header check on the window plus the incoming eighth byte
    assign hdr_len  = {byte_item.data_byte, win_reg[HDR_BYTES-2]};
    assign hdr_ok   = (win_reg[0] == magic_reg) && (win_reg[1] == version_reg)
                   && (win_reg[2] >= type_min_reg) && (win_reg[2] <= type_max_reg)
                   && (hdr_len <= 16'(MAX_PAYLOAD));
    assign seen_inc = seen_reg + LEN_W'(1);

    // next state and result for one byte
    always_comb
    begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        ltype_next      = ltype_reg;
        lflags_next     = lflags_reg;
        lseq_next       = lseq_reg;
        llen_next       = llen_reg;
        seen_next       = seen_reg;
        resync_next     = resync_reg;
        frames_next     = frames_reg;
        ev              = EV_HELD;
        pbyte           = 8'd0;
        last            = 1'b0;

        if (byte_item.clear)
        begin
            ev              = (in_payload_reg || fill_reg != '0) ? EV_DISCARD : EV_IDLE;
            fill_next       = '0;
            in_payload_next = 1'b0;
            seen_next       = '0;
        end
        else if (in_payload_reg)
        begin
            ev    = EV_PAYLOAD;
            pbyte = byte_item.data_byte;
            if (seen_inc >= llen_reg)
            begin
                last            = 1'b1;
                in_payload_next = 1'b0;
                seen_next       = '0;
                frames_next     = frames_reg + 16'd1;
            end
            else
            begin
                seen_next = seen_inc;
            end
        end
        else
        begin
            win_next[fill_reg] = byte_item.data_byte;
            if (fill_reg == FILL_W'(HDR_BYTES - 1))
            begin
                if (hdr_ok)
                begin
                    ltype_next  = win_reg[2];
                    lflags_next = win_reg[3];
                    lseq_next   = {win_reg[5], win_reg[4]};
                    llen_next   = hdr_len[LEN_W-1:0];
                    fill_next   = '0;
                    seen_next   = '0;
                    if (hdr_len == 16'd0)
                    begin
                        ev          = EV_EMPTY;
                        last        = 1'b1;
                        frames_next = frames_reg + 16'd1;
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                    end
                end
                else
                begin
                    // drop the oldest byte and slide the window down
                    for (int i = 0; i < HDR_BYTES - 2; i++)
                    begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[HDR_BYTES-2] = byte_item.data_byte;
                    fill_next   = FILL_W'(HDR_BYTES - 1);
                    resync_next = resync_reg + 16'd1;
                    ev          = EV_RESYNC;
                end
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        res_item_next.event_res    = ev;
        res_item_next.frame_type   = ltype_next;
        res_item_next.frame_flags  = lflags_next;
        res_item_next.frame_seq    = lseq_next;
        res_item_next.frame_length = llen_next;
        res_item_next.payload_byte = pbyte;
        res_item_next.last         = last;
        res_item_next.resync_count = resync_next;
        res_item_next.frame_count  = frames_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg    <= 8'd0;
            version_reg  <= 8'd0;
            type_min_reg <= 8'd0;
            type_max_reg <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAGIC:    magic_reg    <= cfg_data;
                REG_VERSION:  version_reg  <= cfg_data;
                REG_TYPE_MIN: type_min_reg <= cfg_data;
                REG_TYPE_MAX: type_max_reg <= cfg_data;
                default:      magic_reg    <= magic_reg;
            endcase
        end
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            ltype_reg      <= 8'd0;
            lflags_reg     <= 8'd0;
            lseq_reg       <= 16'd0;
            llen_reg       <= '0;
            seen_reg       <= '0;
            resync_reg     <= 16'd0;
            frames_reg     <= 16'd0;
        end
        else if (byte_accept)
        begin
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            ltype_reg      <= ltype_next;
            lflags_reg     <= lflags_next;
            lseq_reg       <= lseq_next;
            llen_reg       <= llen_next;
            seen_reg       <= seen_next;
            resync_reg     <= resync_next;
            frames_reg     <= frames_next;
        end
    end

    // header window, entries above the fill level are don't care
    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            win_reg <= win_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (byte_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            res_item_reg <= res_item_next;
        end
    end

    // checks
    `ASSERT_SAME(a_payload_empty_window, clk, rst_n, in_payload_reg, fill_reg == '0)
    `ASSERT_SAME(a_seen_below_length, clk, rst_n, in_payload_reg, seen_reg < llen_reg)
    `ASSERT_NEXT(a_clear_resets, clk, rst_n, byte_accept && byte_item.clear, !in_payload_reg && fill_reg == '0)
    `ASSERT_SAME(a_last_event, clk, rst_n, res_valid_reg && res_item_reg.last, res_item_reg.event_res == EV_PAYLOAD || res_item_reg.event_res == EV_EMPTY)

endmodule

### verif/magic_header_deframer_resync_unit_test.sv
// self-checking testbench for magic_header_deframer_resync_unit: a directed script,
// then random framed traffic under several register settings
// depends on mhdr_pkg and the deframer rtl only
module magic_header_deframer_resync_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mhdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 205;
    localparam int REPORT_LIMIT   = 10;

    // directed script row: byte, link-down flag, event and last read off by hand
    typedef struct packed {
        logic [7:0] data;
        logic       clear_link;
        event_t     ev;
        logic       last;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    byte_item_t  byte_item;
    logic        res_valid;
    logic        res_ready;
    res_item_t   res_item;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_reg_t    cfg_index;
    logic [7:0]  cfg_data;

    // register shadow, at reset values
    logic [7:0] cfg_magic   = 8'h00;
    logic [7:0] cfg_version = 8'h00;
    logic [7:0] cfg_type_lo = 8'h00;
    logic [7:0] cfg_type_hi = 8'hFF;

    // deframer state as the predictor sees it
    logic [7:0]       hdr_win [8];
    int unsigned      hdr_fill   = 0;
    bit               in_frame   = 1'b0;
    logic [7:0]       cur_type   = '0;
    logic [7:0]       cur_flags  = '0;
    logic [15:0]      cur_seq    = '0;
    logic [LEN_W-1:0] cur_len    = '0;
    int unsigned      pay_count  = 0;
    logic [15:0]      resync_cnt = '0;
    logic [15:0]      frame_cnt  = '0;

    res_item_t predicted_results [$];
    res_item_t predicted;
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        send_gap_pct   = 0;
    int        stall_pct      = 0;
    bit        row_typed      = 1'b0;
    event_t    row_ev         = EV_HELD;
    bit        row_last       = 1'b0;

    // idle after reset, a held header, a one-byte frame, an empty frame,
    // an over-long length that forces a resync, then link down with bytes held
    script_row_t script [27] = '{
        '{8'h00, 1'b1, EV_IDLE,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'hFF, 1'b0, EV_HELD,    1'b0},
        '{8'hFF, 1'b0, EV_HELD,    1'b0},
        '{8'hFF, 1'b0, EV_HELD,    1'b0},
        '{8'hFF, 1'b0, EV_HELD,    1'b0},
        '{8'h01, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'hFF, 1'b0, EV_PAYLOAD, 1'b1},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_EMPTY,   1'b1},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h00, 1'b0, EV_HELD,    1'b0},
        '{8'h01, 1'b0, EV_HELD,    1'b0},
        '{8'h02, 1'b0, EV_RESYNC,  1'b0},
        '{8'h5A, 1'b1, EV_DISCARD, 1'b0}
    };

    magic_header_deframer_resync_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(99, 0) < 80)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // advance the deframer state by one byte and return the result it causes
    function automatic res_item_t deframe_step(input logic [7:0] d, input logic clr);
        res_item_t   r;
        logic [15:0] hlen;
        bit          hdr_ok;
        int          i;
        r = '0;
        r.event_res = EV_HELD;
        if (clr)
        begin
            // link down: anything in flight is thrown away
            r.event_res = (in_frame || hdr_fill != 0) ? EV_DISCARD : EV_IDLE;
            hdr_fill = 0;
            in_frame = 1'b0;
            pay_count = 0;
        end
        else if (in_frame)
        begin
            r.event_res = EV_PAYLOAD;
            r.payload_byte = d;
            pay_count++;
            if (pay_count >= cur_len)
            begin
                r.last = 1'b1;
                in_frame = 1'b0;
                pay_count = 0;
                frame_cnt++;
            end
        end
        else
        begin
            hdr_win[hdr_fill] = d;
            hdr_fill++;
            if (hdr_fill == 8)
            begin
                hlen = {hdr_win[7], hdr_win[6]};
                hdr_ok = hdr_win[0] == cfg_magic && hdr_win[1] == cfg_version &&
                         hdr_win[2] >= cfg_type_lo && hdr_win[2] <= cfg_type_hi &&
                         hlen <= MAX_PAYLOAD;
                if (hdr_ok)
                begin
                    cur_type = hdr_win[2];
                    cur_flags = hdr_win[3];
                    cur_seq = {hdr_win[5], hdr_win[4]};
                    cur_len = hlen[LEN_W-1:0];
                    hdr_fill = 0;
                    pay_count = 0;
                    if (cur_len == 0)
                    begin
                        r.event_res = EV_EMPTY;
                        r.last = 1'b1;
                        frame_cnt++;
                    end
                    else
                        in_frame = 1'b1;
                end
                else
                begin
                    // drop the oldest byte and slide the window
                    for (i = 0; i < 7; i++)
                        hdr_win[i] = hdr_win[i + 1];
                    hdr_fill = 7;
                    resync_cnt++;
                    r.event_res = EV_RESYNC;
                end
            end
        end
        r.frame_type = cur_type;
        r.frame_flags = cur_flags;
        r.frame_seq = cur_seq;
        r.frame_length = cur_len;
        r.resync_count = resync_cnt;
        r.frame_count = frame_cnt;
        return r;
    endfunction

    // compare one result item against the oldest prediction
    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (predicted_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("result item with no prediction: event %0d", got.event_res);
            return;
        end
        want = predicted_results.pop_front();
        if (got.event_res !== want.event_res || got.frame_type !== want.frame_type ||
            got.frame_flags !== want.frame_flags || got.frame_seq !== want.frame_seq ||
            got.frame_length !== want.frame_length ||
            got.payload_byte !== want.payload_byte || got.last !== want.last ||
            got.resync_count !== want.resync_count || got.frame_count !== want.frame_count)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display({"mismatch (exp/got): ev %0d/%0d type %h/%h flags %h/%h seq %h/%h",
                          " len %0d/%0d byte %h/%h last %b/%b resync %0d/%0d frames %0d/%0d"},
                         want.event_res, got.event_res, want.frame_type, got.frame_type,
                         want.frame_flags, got.frame_flags, want.frame_seq, got.frame_seq,
                         want.frame_length, got.frame_length, want.payload_byte,
                         got.payload_byte, want.last, got.last, want.resync_count,
                         got.resync_count, want.frame_count, got.frame_count);
        end
    endtask

    // result check and prediction, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                check_result(res_item);
            if (byte_valid && byte_ready)
            begin
                predicted = deframe_step(byte_item.data_byte, byte_item.clear);
                if (row_typed)
                begin
                    predicted.event_res = row_ev;
                    predicted.last = row_last;
                end
                predicted_results.push_back(predicted);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side back-pressure
    initial
    begin
        int hold;
        hold = 0;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_ready = 1'b0;
                hold--;
            end
            else
            begin
                res_ready = 1'b1;
                if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct)
                    hold = pick_gap();
            end
        end
    end

    // offer one byte item and hold it until taken; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] d, input logic clr, input bit typed,
                             input event_t ev, input bit lst);
        int gap;
        if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct)
        begin
            gap = pick_gap();
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_typed = typed;
        row_ev = ev;
        row_last = lst;
        byte_item.data_byte = d;
        byte_item.clear = clr;
        byte_valid = 1'b1;
        do @(posedge clk); while (!byte_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // write all four registers once the block has gone quiet
    task automatic configure(input logic [7:0] magic, input logic [7:0] version,
                             input logic [7:0] tmin, input logic [7:0] tmax);
        byte_valid = 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, version);
        write_reg(REG_TYPE_MIN, tmin);
        write_reg(REG_TYPE_MAX, tmax);
        cfg_valid = 1'b0;
        cfg_magic = magic;
        cfg_version = version;
        cfg_type_lo = tmin;
        cfg_type_hi = tmax;
    endtask

    // random traffic: mostly well-formed frames, some noise, corruption and link drops
    task automatic run_phase(input int n_items, input int gap_pct, input int hold_pct);
        logic [8:0]  burst [$];
        logic [7:0]  hdr [8];
        logic [15:0] len;
        logic [8:0]  item;
        int          sent;
        int          pick;
        int          k;
        bit          quiet;
        sent = 0;
        while (sent < n_items)
        begin
            // some stretches run with no idling on either side
            quiet = ($urandom_range(99, 0) < 15);
            send_gap_pct = quiet ? 0 : gap_pct;
            stall_pct = quiet ? 0 : hold_pct;
            pick = $urandom_range(99, 0);
            burst.delete();
            if (pick < 10)
            begin
                // line noise
                repeat ($urandom_range(6, 1))
                    burst.push_back({1'b0, 8'($urandom)});
            end
            else if (pick < 14)
                burst.push_back({1'b1, 8'($urandom)});
            else
            begin
                hdr[0] = cfg_magic;
                hdr[1] = cfg_version;
                if (cfg_type_lo <= cfg_type_hi)
                    hdr[2] = 8'($urandom_range(cfg_type_hi, cfg_type_lo));
                else
                    hdr[2] = 8'($urandom);
                hdr[3] = 8'($urandom);
                hdr[4] = 8'($urandom);
                hdr[5] = 8'($urandom);
                // mostly short payloads, rarely the largest or an illegal length
                pick = $urandom_range(199, 0);
                if (pick == 0)
                    len = 16'(MAX_PAYLOAD);
                else if (pick == 1)
                    len = 16'($urandom_range(MAX_PAYLOAD - 1, MAX_PAYLOAD - 32));
                else if (pick < 8)
                    len = 16'($urandom_range(65535, MAX_PAYLOAD + 1));
                else if (pick < 20)
                    len = 16'($urandom_range(60, 13));
                else
                    len = 16'($urandom_range(12, 0));
                hdr[6] = len[7:0];
                hdr[7] = len[15:8];
                // occasional bit error in magic, version or type
                if ($urandom_range(99, 0) < 8)
                begin
                    k = $urandom_range(2, 0);
                    hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(7, 0));
                end
                for (k = 0; k < 8; k++)
                    burst.push_back({1'b0, hdr[k]});
                if (len <= MAX_PAYLOAD)
                    for (k = 0; k < len; k++)
                        burst.push_back({1'b0, 8'($urandom)});
                // occasional link drop part way through
                if ($urandom_range(99, 0) < 5)
                begin
                    k = $urandom_range(burst.size() - 1, 1);
                    while (burst.size() > k)
                        void'(burst.pop_back());
                    burst.push_back({1'b1, 8'($urandom)});
                end
            end
            while (burst.size() != 0 && sent < n_items)
            begin
                item = burst.pop_front();
                send_byte(item[7:0], item[8], 1'b0, EV_HELD, 1'b0);
                sent++;
            end
        end
        send_byte(8'($urandom), 1'b1, 1'b0, EV_HELD, 1'b0);
    endtask

    // main sequence
    initial
    begin
        int n;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAGIC;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed script at reset register values
        send_gap_pct = 20;
        stall_pct = 20;
        foreach (script[i])
            send_byte(script[i].data, script[i].clear_link, 1'b1, script[i].ev,
                      script[i].last);

        // random traffic under several register settings
        configure(8'hA5, 8'h01, 8'h10, 8'h20);
        run_phase(PHASE_ITEMS, 30, 30);
        configure(8'hFF, 8'hFF, 8'h00, 8'hFF);
        run_phase(PHASE_ITEMS, 10, 50);
        // empty type range: nothing is ever a valid header
        configure(8'h00, 8'h00, 8'h80, 8'h7F);
        run_phase(PHASE_ITEMS, 40, 10);
        n = $urandom_range(255, 0);
        configure(8'($urandom), 8'($urandom), 8'(n), 8'(n));
        run_phase(PHASE_ITEMS, 20, 20);
        configure(8'h3C, 8'hC3, 8'h00, 8'h00);
        run_phase(PHASE_ITEMS, 5, 5);
        configure(8'h5A, 8'h00, 8'hFF, 8'hFF);
        run_phase(PHASE_ITEMS, 25, 35);

        // drain and settle
        byte_valid = 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/mhdr_pkg.sv
design/magic_header_deframer_resync_unit.sv
verif/magic_header_deframer_resync_unit_test.sv
